[design/gtbs_pkg.sv]
// shared types and constants for the genotype tally by sex block
`default_nettype none
package gtbs_pkg;
    localparam int NumAlleles = 4;
    localparam int CountW = 11;
    localparam int TallyW = 17;
    localparam int SiteErrW = 27;
    localparam int ThetaW = 33;
    localparam int CallsW = 27;
    localparam int ErrSumW = 43;
    localparam int QuotW = 17;
    localparam int DivW = 43;
    localparam int DivCntW = 6;
    localparam logic [TallyW-1:0] OneQ16 = 17'd65536;

    typedef struct packed {
        logic accept;
        logic close_site;
        logic start_theta;
        logic start_err;
        logic emit_site;
        logic emit_summary;
        logic clear_contig;
    } t_cmd;

    typedef struct packed {
        logic site_ok;
        logic div_done;
    } t_status;

    typedef struct packed {
        logic                 kind;
        logic [31:0]          pos_calls;
        logic [TallyW-1:0]    t1;
        logic [TallyW-1:0]    t2;
        logic [TallyW-1:0]    t3;
        logic [TallyW-1:0]    t4;
        logic [TallyW-1:0]    t5;
        logic [TallyW-1:0]    t6;
        logic [1:0]           lo;
        logic [1:0]           hi;
        logic [QuotW-1:0]     theta;
        logic [QuotW-1:0]     err;
    } t_rec;
endpackage
`default_nettype wire

[design/gtbs_div.sv]
// restoring divider, one quotient bit per cycle, quotient saturated to 17 bits
`default_nettype none
module gtbs_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [gtbs_pkg::DivW-1:0]    i_num,
    input  wire logic [gtbs_pkg::DivW-1:0]    i_den,
    output logic                              o_done,
    output logic [gtbs_pkg::QuotW-1:0]        o_quot
);
    logic [gtbs_pkg::DivW-1:0] r_rem, n_rem, r_quo, n_quo, r_num, n_num, r_den;
    logic [gtbs_pkg::DivCntW-1:0] r_cnt, n_cnt;
    logic r_busy, n_busy, r_done, n_done;
    logic [gtbs_pkg::DivW:0] w_trial;

    always_comb begin
        n_rem = r_rem; n_quo = r_quo; n_num = r_num; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        w_trial = {r_rem, r_num[gtbs_pkg::DivW-1]};
        if (i_start) begin
            n_rem = '0; n_quo = '0; n_num = i_num;
            n_cnt = gtbs_pkg::DivCntW'(gtbs_pkg::DivW);
            n_busy = (i_den != '0);
            n_done = (i_den == '0);
        end else if (r_busy) begin
            n_num = {r_num[gtbs_pkg::DivW-2:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = gtbs_pkg::DivW'(w_trial - {1'b0, r_den});
                n_quo = {r_quo[gtbs_pkg::DivW-2:0], 1'b1};
            end else begin
                n_rem = w_trial[gtbs_pkg::DivW-1:0];
                n_quo = {r_quo[gtbs_pkg::DivW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == gtbs_pkg::DivCntW'(1)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_rem <= n_rem; r_quo <= n_quo; r_num <= n_num;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quot = (r_quo[gtbs_pkg::DivW-1:gtbs_pkg::QuotW] != '0) ? '1
                  : r_quo[gtbs_pkg::QuotW-1:0];
endmodule
`default_nettype wire

[design/gtbs_datapath.sv]
// tallies, contig totals, two dividers and the output register
`default_nettype none
module gtbs_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire gtbs_pkg::t_cmd              i_cmd,
    output gtbs_pkg::t_status                o_status,
    input  wire logic                        i_cfg_we,
    input  wire logic [16:0]                 i_cfg_data,
    input  wire logic [2:0]                  i_a1,
    input  wire logic [2:0]                  i_a2,
    input  wire logic [1:0]                  i_sex,
    input  wire logic [16:0]                 i_prob,
    input  wire logic [31:0]                 i_pos,
    output gtbs_pkg::t_rec                   o_rec
);
    localparam int CW = gtbs_pkg::CountW;
    localparam int TW = gtbs_pkg::TallyW;
    localparam logic [CW-1:0] CMax = '1;
    localparam logic [TW-1:0] TMax = '1;

    logic [16:0] r_wr;
    logic [CW-1:0] r_allele [gtbs_pkg::NumAlleles];
    logic [CW-1:0] r_hom [2*gtbs_pkg::NumAlleles];
    logic [CW-1:0] r_fhet, r_mhet, r_scalls;
    logic [gtbs_pkg::SiteErrW-1:0] r_serr;
    logic [TW-1:0] r_sites, r_three, r_four;
    logic [gtbs_pkg::ThetaW-1:0] r_theta;
    logic [gtbs_pkg::CallsW-1:0] r_ccalls;
    logic [gtbs_pkg::ErrSumW-1:0] r_cerr;
    logic [31:0] r_pos;
    logic [1:0] r_lo, r_hi;
    logic [CW-1:0] r_f1, r_f2, r_m1, r_m2, r_ofhet, r_omhet;
    logic r_site_ok;
    logic r_tdone, r_edone;
    logic [gtbs_pkg::QuotW-1:0] r_qtheta;
    logic [TW-1:0] r_o3, r_o4;
    logic [gtbs_pkg::CallsW-1:0] r_occ;
    gtbs_pkg::t_rec r_rec;

    logic v1, v2, comp, hom;
    logic [1:0] x1, x2;
    logic [16:0] pc;
    logic [2:0] div_n;
    logic [1:0] lo, hi;
    logic [CW+1:0] fsum, msum;
    logic [gtbs_pkg::SiteErrW:0] serr_add;
    logic [gtbs_pkg::ThetaW:0] th_add;
    logic [gtbs_pkg::CallsW:0] cc_add;
    logic [gtbs_pkg::ErrSumW:0] ce_add;
    logic [2:0] hslot;
    logic dv_done_t, dv_done_e;
    logic [gtbs_pkg::QuotW-1:0] q_t, q_e;

    assign v1 = !i_a1[2];
    assign v2 = !i_a2[2];
    assign x1 = i_a1[1:0];
    assign x2 = i_a2[1:0];
    assign comp = v1 && v2;
    // two missing codes count as equal
    assign hom = (v1 == v2) && (!v1 || x1 == x2);
    assign pc = (i_prob > gtbs_pkg::OneQ16) ? gtbs_pkg::OneQ16 : i_prob;
    assign hslot = {i_sex[0], x1};
    assign serr_add = {1'b0, r_serr} + (gtbs_pkg::SiteErrW+1)'(gtbs_pkg::OneQ16 - pc);

    always_comb begin
        div_n = '0; lo = '0; hi = '0;
        for (int k = 0; k < gtbs_pkg::NumAlleles; k++) begin
            if (r_allele[k] != '0) begin
                if (div_n == 3'd0) lo = 2'(k);
                else if (div_n == 3'd1) hi = 2'(k);
                div_n = div_n + 3'd1;
            end
        end
    end

    assign fsum = {2'b0, r_hom[{1'b0, lo}]} + {2'b0, r_hom[{1'b0, hi}]} + {2'b0, r_fhet};
    assign msum = {2'b0, r_hom[{1'b1, lo}]} + {2'b0, r_hom[{1'b1, hi}]} + {2'b0, r_mhet};
    assign th_add = {1'b0, r_theta} + (gtbs_pkg::ThetaW+1)'(r_wr);
    assign cc_add = {1'b0, r_ccalls} + (gtbs_pkg::CallsW+1)'(r_scalls);
    assign ce_add = {1'b0, r_cerr} + (gtbs_pkg::ErrSumW+1)'(r_serr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            for (int k = 0; k < gtbs_pkg::NumAlleles; k++) r_allele[k] <= '0;
            for (int k = 0; k < 2*gtbs_pkg::NumAlleles; k++) r_hom[k] <= '0;
            r_fhet <= '0; r_mhet <= '0; r_scalls <= '0; r_serr <= '0;
            r_sites <= '0; r_three <= '0; r_four <= '0; r_theta <= '0;
            r_ccalls <= '0; r_cerr <= '0; r_site_ok <= 1'b0;
            r_tdone <= 1'b0; r_edone <= 1'b0;
        end else begin
            if (i_cfg_we) r_wr <= i_cfg_data;
            if (i_cmd.accept) begin
                if (v1 && !(v2 && x1 == x2) && r_allele[x1] != CMax)
                    r_allele[x1] <= r_allele[x1] + 1'b1;
                if (v2 && !(v1 && x1 == x2) && r_allele[x2] != CMax)
                    r_allele[x2] <= r_allele[x2] + 1'b1;
                if (comp && x1 == x2)
                    r_allele[x1] <= (r_allele[x1] >= CMax - 1'b1) ? CMax
                                  : r_allele[x1] + 2'd2;
                if (comp) begin
                    if (r_scalls != CMax) r_scalls <= r_scalls + 1'b1;
                    r_serr <= serr_add[gtbs_pkg::SiteErrW] ? '1
                            : serr_add[gtbs_pkg::SiteErrW-1:0];
                end
                if (!i_sex[1]) begin
                    if (hom) begin
                        if (v1 && r_hom[hslot] != CMax) r_hom[hslot] <= r_hom[hslot] + 1'b1;
                    end else if (!i_sex[0]) begin
                        if (r_fhet != CMax) r_fhet <= r_fhet + 1'b1;
                    end else begin
                        if (r_mhet != CMax) r_mhet <= r_mhet + 1'b1;
                    end
                end
            end
            if (i_cmd.close_site) begin
                if (r_sites != TMax) r_sites <= r_sites + 1'b1;
                if (div_n > 3'd1)
                    r_theta <= th_add[gtbs_pkg::ThetaW] ? '1 : th_add[gtbs_pkg::ThetaW-1:0];
                r_site_ok <= (div_n == 3'd2) && (fsum != '0) && (msum != '0);
                if (div_n == 3'd2) begin
                    r_ccalls <= cc_add[gtbs_pkg::CallsW] ? '1 : cc_add[gtbs_pkg::CallsW-1:0];
                    r_cerr <= ce_add[gtbs_pkg::ErrSumW] ? '1 : ce_add[gtbs_pkg::ErrSumW-1:0];
                end else if (div_n == 3'd3) begin
                    if (r_three != TMax) r_three <= r_three + 1'b1;
                end else if (div_n == 3'd4) begin
                    if (r_four != TMax) r_four <= r_four + 1'b1;
                end
                for (int k = 0; k < gtbs_pkg::NumAlleles; k++) r_allele[k] <= '0;
                for (int k = 0; k < 2*gtbs_pkg::NumAlleles; k++) r_hom[k] <= '0;
                r_fhet <= '0; r_mhet <= '0; r_scalls <= '0; r_serr <= '0;
            end
            if (i_cmd.clear_contig) begin
                r_sites <= '0; r_three <= '0; r_four <= '0; r_theta <= '0;
                r_ccalls <= '0; r_cerr <= '0;
            end
            if (i_cmd.start_theta) r_tdone <= 1'b0;
            else if (dv_done_t) r_tdone <= 1'b1;
            if (i_cmd.start_err) r_edone <= 1'b0;
            else if (dv_done_e) r_edone <= 1'b1;
        end
        if (i_cmd.accept) r_pos <= i_pos;
        if (i_cmd.close_site) begin
            r_lo <= lo; r_hi <= hi;
            r_f1 <= r_hom[{1'b0, lo}]; r_f2 <= r_hom[{1'b0, hi}];
            r_m1 <= r_hom[{1'b1, lo}]; r_m2 <= r_hom[{1'b1, hi}];
            r_ofhet <= r_fhet; r_omhet <= r_mhet;
        end
        if (i_cmd.start_err) begin
            r_o3 <= r_three; r_o4 <= r_four; r_occ <= r_ccalls;
        end
        if (dv_done_t) r_qtheta <= q_t;
        if (i_cmd.emit_site) begin
            r_rec.kind <= 1'b0;
            r_rec.pos_calls <= r_pos;
            r_rec.t1 <= TW'(r_f1); r_rec.t2 <= TW'(r_ofhet); r_rec.t3 <= TW'(r_f2);
            r_rec.t4 <= TW'(r_m1); r_rec.t5 <= TW'(r_omhet); r_rec.t6 <= TW'(r_m2);
            r_rec.lo <= r_lo; r_rec.hi <= r_hi;
            r_rec.theta <= '0; r_rec.err <= '0;
        end else if (i_cmd.emit_summary) begin
            r_rec.kind <= 1'b1;
            r_rec.pos_calls <= 32'(r_occ);
            r_rec.t1 <= r_o3; r_rec.t2 <= r_o4;
            r_rec.t3 <= '0; r_rec.t4 <= '0; r_rec.t5 <= '0; r_rec.t6 <= '0;
            r_rec.lo <= '0; r_rec.hi <= '0;
            r_rec.theta <= r_qtheta; r_rec.err <= q_e;
        end
    end

    gtbs_div u_div_theta (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.start_theta),
        .i_num(gtbs_pkg::DivW'(r_theta)), .i_den(gtbs_pkg::DivW'(r_sites)),
        .o_done(dv_done_t), .o_quot(q_t)
    );
    gtbs_div u_div_err (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.start_err),
        .i_num(r_cerr), .i_den(gtbs_pkg::DivW'(r_ccalls)),
        .o_done(dv_done_e), .o_quot(q_e)
    );

    assign o_status.site_ok = r_site_ok;
    assign o_status.div_done = r_tdone && r_edone;
    assign o_rec = r_rec;
endmodule
`default_nettype wire

[design/gtbs_ctrl.sv]
// controller: item intake, site close, division wait and result delivery
`default_nettype none
module gtbs_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_last_site,
    input  wire logic                 i_last_contig,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output gtbs_pkg::t_cmd            o_cmd,
    input  wire gtbs_pkg::t_status    i_status
);
    localparam logic [2:0] SIdle = 3'd0, SClose = 3'd1, SCheck = 3'd2,
                           SSend = 3'd3, SDiv = 3'd4, SSum = 3'd5;
    logic [2:0] r_state, n_state;
    logic r_contig, n_contig, r_valid, n_valid, r_sum_next, n_sum_next;
    logic acc, free;

    assign free = !r_valid || i_out_ready;
    assign o_in_ready = (r_state == SIdle);
    assign acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state; n_contig = r_contig; n_sum_next = r_sum_next;
        n_valid = r_valid && !i_out_ready;
        o_cmd = '0;
        o_cmd.accept = acc;
        case (r_state)
            SIdle: if (acc && i_last_site) begin
                n_contig = i_last_contig; n_state = SClose;
            end
            SClose: begin
                o_cmd.close_site = 1'b1; n_state = SCheck;
            end
            SCheck: begin
                if (r_contig) begin
                    o_cmd.start_theta = 1'b1; o_cmd.start_err = 1'b1;
                    o_cmd.clear_contig = 1'b1;
                end
                if (i_status.site_ok) n_state = SSend;
                else if (r_contig) n_state = SDiv;
                else n_state = SIdle;
            end
            SSend: if (free) begin
                o_cmd.emit_site = 1'b1; n_valid = 1'b1;
                n_state = r_contig ? SDiv : SIdle;
            end
            SDiv: if (i_status.div_done) n_state = SSum;
            SSum: if (free) begin
                o_cmd.emit_summary = 1'b1; n_valid = 1'b1; n_state = SIdle;
            end
            default: n_state = SIdle;
        endcase
        n_sum_next = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SIdle; r_contig <= 1'b0; r_valid <= 1'b0; r_sum_next <= 1'b0;
        end else begin
            r_state <= n_state; r_contig <= n_contig; r_valid <= n_valid;
            r_sum_next <= n_sum_next;
        end
    end

    assign o_out_valid = r_valid && !r_sum_next;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == SIdle) else $error("ready outside idle");
    a_close_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_last_site) |=> o_cmd.close_site) else $error("site not closed");
    a_emit_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.emit_site && o_cmd.emit_summary)) else $error("double emit");
`endif
endmodule
`default_nettype wire

[design/genotype_tally_by_sex_core.sv]
// top level of the genotype tally by sex block
// One item per cycle while a site is open. The item that closes a site is followed by
// site evaluation in SClose and SCheck, and in SSend when it yields a site record, plus any
// wait for the output register to empty, before the next item is taken; a contig close adds the
// wait for the two bit-serial dividers (43 quotient bits each, run side by side). Output holds in a
// register; the controller waits for it to be taken before loading another result.
`default_nettype none
module genotype_tally_by_sex_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [16:0]   i_cfg_data,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [63:0]   s_axis_tdata, // first_allele, second_allele, sex_code, call_probability, site_position
    input  wire logic          s_axis_tuser, // last_of_contig
    input  wire logic          s_axis_tlast,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [175:0]       m_axis_tdata, // position_or_calls, tally_1..6, low_allele_index, high_allele_index, theta_per_site, mean_error
    output logic               m_axis_tuser  // record_kind
);
    gtbs_pkg::t_cmd cmd;
    gtbs_pkg::t_status st;
    gtbs_pkg::t_rec rec;

    gtbs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .i_last_site(s_axis_tlast), .i_last_contig(s_axis_tuser),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready), .o_cmd(cmd), .i_status(st)
    );
    gtbs_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(st),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_a1(s_axis_tdata[2:0]), .i_a2(s_axis_tdata[5:3]), .i_sex(s_axis_tdata[7:6]),
        .i_prob(s_axis_tdata[24:8]), .i_pos(s_axis_tdata[56:25]), .o_rec(rec)
    );

    assign m_axis_tuser = rec.kind;
    assign m_axis_tdata = {4'd0, rec.err, rec.theta, rec.hi, rec.lo, rec.t6, rec.t5,
                           rec.t4, rec.t3, rec.t2, rec.t1, rec.pos_calls};
    logic unused_ok;
    assign unused_ok = ^s_axis_tdata[63:57];
endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// self-checking testbench for the genotype tally by sex block
`default_nettype none
module testbench;

    typedef struct {
        logic        kind;
        logic [31:0] pos_calls;
        logic [16:0] t1, t2, t3, t4, t5, t6;
        logic [1:0]  lo, hi;
        logic [16:0] theta, err;
    } t_exp_rec;

    class tally_scoreboard;
        logic [16:0] recip;
        int unsigned allele_cnt[4];
        int unsigned hom_cnt[8];
        int unsigned fhet, mhet, site_calls;
        longint unsigned site_err;
        int unsigned sites, three_sites, four_sites;
        longint unsigned theta_acc, contig_calls, contig_err;
        t_exp_rec pending[$];
        int errors;
        int site_recs, summaries;

        function void clear_site();
            foreach (allele_cnt[k]) allele_cnt[k] = 0;
            foreach (hom_cnt[k]) hom_cnt[k] = 0;
            fhet = 0; mhet = 0; site_calls = 0; site_err = 0;
        endfunction

        function void clear_contig();
            sites = 0; theta_acc = 0; three_sites = 0; four_sites = 0;
            contig_calls = 0; contig_err = 0;
        endfunction

        function int unsigned sat(longint unsigned v, longint unsigned mx);
            return 32'((v > mx) ? mx : v);
        endfunction

        function longint unsigned satl(longint unsigned v, longint unsigned mx);
            return (v > mx) ? mx : v;
        endfunction

        function int allele_of(logic [2:0] c);
            if (c[2] || c >= 3'd4) return -1;
            return int'(c);
        endfunction

        function void note_call(logic [2:0] c1, logic [2:0] c2, logic [1:0] sx,
                                logic [16:0] p, logic [31:0] pos, bit eos, bit eoc);
            int a1, a2, n, lo, hi;
            logic [16:0] pc;
            t_exp_rec r;
            a1 = allele_of(c1);
            a2 = allele_of(c2);
            if (a1 >= 0) allele_cnt[a1] = sat(allele_cnt[a1] + 1, 2047);
            if (a2 >= 0) allele_cnt[a2] = sat(allele_cnt[a2] + 1, 2047);
            if (a1 >= 0 && a2 >= 0) begin
                pc = (p > gtbs_pkg::OneQ16) ? gtbs_pkg::OneQ16 : p;
                site_calls = sat(site_calls + 1, 2047);
                site_err = satl(site_err + (65536 - pc), 64'h7FFFFFF);
            end
            if (sx < 2) begin
                if (a1 == a2) begin
                    if (a1 >= 0) hom_cnt[sx * 4 + a1] = sat(hom_cnt[sx * 4 + a1] + 1, 2047);
                end else if (sx == 0) begin
                    fhet = sat(fhet + 1, 2047);
                end else begin
                    mhet = sat(mhet + 1, 2047);
                end
            end
            if (!eos) return;
            n = 0; lo = 0; hi = 0;
            for (int k = 0; k < 4; k++) begin
                if (allele_cnt[k] > 0) begin
                    if (n == 0) lo = k;
                    else if (n == 1) hi = k;
                    n++;
                end
            end
            sites = sat(sites + 1, 17'h1FFFF);
            if (n > 1) theta_acc = satl(theta_acc + recip, 64'h1FFFFFFFF);
            if (n == 2) begin
                contig_calls = satl(contig_calls + site_calls, 64'h7FFFFFF);
                contig_err = satl(contig_err + site_err, 64'h7FFFFFFFFFF);
                if (hom_cnt[lo] + hom_cnt[hi] + fhet != 0 &&
                    hom_cnt[4 + lo] + hom_cnt[4 + hi] + mhet != 0) begin
                    r.kind = 1'b0; r.pos_calls = pos;
                    r.t1 = 17'(hom_cnt[lo]); r.t2 = 17'(fhet); r.t3 = 17'(hom_cnt[hi]);
                    r.t4 = 17'(hom_cnt[4 + lo]); r.t5 = 17'(mhet);
                    r.t6 = 17'(hom_cnt[4 + hi]);
                    r.lo = 2'(lo); r.hi = 2'(hi); r.theta = '0; r.err = '0;
                    pending.insert(pending.size(), r);
                end
            end else if (n == 3) begin
                three_sites = sat(three_sites + 1, 17'h1FFFF);
            end else if (n == 4) begin
                four_sites = sat(four_sites + 1, 17'h1FFFF);
            end
            clear_site();
            if (eoc) begin
                r.kind = 1'b1; r.pos_calls = contig_calls[31:0];
                r.t1 = 17'(three_sites); r.t2 = 17'(four_sites);
                r.t3 = '0; r.t4 = '0; r.t5 = '0; r.t6 = '0; r.lo = '0; r.hi = '0;
                r.theta = 17'(satl(sites ? theta_acc / sites : 0, 17'h1FFFF));
                r.err = 17'(satl(contig_calls ? contig_err / contig_calls : 0, 17'h1FFFF));
                pending.insert(pending.size(), r);
                clear_contig();
            end
        endfunction

        function void check_record(logic kind, logic [175:0] d);
            t_exp_rec e;
            logic [175:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected record kind %0d data %h", $time, kind, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.kind) summaries++; else site_recs++;
            want = {4'd0, e.err, e.theta, e.hi, e.lo, e.t6, e.t5, e.t4, e.t3, e.t2, e.t1,
                    e.pos_calls};
            if (kind !== e.kind || d !== want) begin
                $display("%0t: mismatch expected kind %0d data %h, actual kind %0d data %h",
                         $time, e.kind, want, kind, d);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk, i_rst_n;
    logic         i_cfg_we;
    logic [16:0]  i_cfg_data;
    logic         s_axis_tvalid, s_axis_tready, s_axis_tuser, s_axis_tlast;
    logic [63:0]  s_axis_tdata;
    logic         m_axis_tvalid, m_axis_tready, m_axis_tuser;
    logic [175:0] m_axis_tdata;

    tally_scoreboard sb;
    int unsigned cycles;
    bit stim_done;

    genotype_tally_by_sex_core i_dut (.*);

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_call(logic [2:0] c1, logic [2:0] c2, logic [1:0] sx,
                             logic [16:0] p, logic [31:0] pos, bit eos, bit eoc);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, pos, p, sx, c2, c1};
        s_axis_tlast <= eos;
        s_axis_tuser <= eoc;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_call(c1, c2, sx, p, pos, eos, eoc);
    endtask

    task automatic drain_and_config(logic [16:0] v);
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.recip = v;
    endtask

    function logic [2:0] pick_allele(int nal, int base);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 3'b111;
        if (r < 10) return 3'($urandom_range(4, 7));
        return 3'(base + $urandom_range(0, nal - 1));
    endfunction

    task automatic random_site(bit eoc);
        int n, nal, base;
        logic [16:0] p;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
        nal = $urandom_range(1, 4);
        base = $urandom_range(0, 4 - nal);
        for (int k = 0; k < n; k++) begin
            p = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(65537, 131071))
                                            : 17'($urandom_range(0, 65536));
            send_call(pick_allele(nal, base), pick_allele(nal, base),
                      2'($urandom_range(0, 3)), p, $urandom, k == n - 1,
                      (k == n - 1) ? eoc : bit'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int sent;
        sb = new();
        sb.recip = 0;
        sb.errors = 0; sb.site_recs = 0; sb.summaries = 0;
        sb.clear_site();
        sb.clear_contig();
        stim_done = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0; s_axis_tlast = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain_and_config(17'd65536);
        // directed: biallelic site with all sexes, half-missing, missing, clamp
        send_call(3'd0, 3'd0, 2'd0, 17'd65536, 32'd0, 0, 0);
        send_call(3'd0, 3'd1, 2'd0, 17'd0, 32'd0, 0, 0);
        send_call(3'd1, 3'd1, 2'd1, 17'h1FFFF, 32'd0, 0, 0);
        send_call(3'd1, 3'b111, 2'd1, 17'd100, 32'd0, 0, 0);
        send_call(3'b111, 3'b111, 2'd2, 17'd5, 32'd0, 0, 0);
        send_call(3'd0, 3'd1, 2'd3, 17'd40000, 32'hFFFFFFFF, 1, 0);
        // only one sex tallied
        send_call(3'd2, 3'd3, 2'd0, 17'd1000, 32'd7, 0, 1);
        send_call(3'd3, 3'd3, 2'd2, 17'd1000, 32'd8, 1, 0);
        // three and four alleles, bad codes
        send_call(3'd0, 3'd1, 2'd0, 17'd1, 32'd9, 0, 0);
        send_call(3'd2, 3'd5, 2'd1, 17'd1, 32'd9, 1, 0);
        send_call(3'd0, 3'd1, 2'd0, 17'd1, 32'd10, 0, 0);
        send_call(3'd2, 3'd3, 2'd1, 17'd1, 32'd10, 1, 0);
        // monomorphic and empty sites
        send_call(3'd2, 3'd2, 2'd1, 17'd3, 32'd11, 1, 0);
        send_call(3'd4, 3'd6, 2'd0, 17'd3, 32'd12, 1, 1);
        drain_and_config(17'd0);
        send_call(3'd6, 3'd6, 2'd0, 17'd3, 32'd13, 1, 1);
        drain_and_config(17'd1);
        sent = 0;
        while (sent < 1500) begin
            int ns;
            ns = $urandom_range(1, 12);
            for (int s = 0; s < ns; s++) begin
                random_site(s == ns - 1);
            end
            sent += ns * 6;
            if ($urandom_range(0, 5) == 0)
                drain_and_config(17'($urandom_range(0, 65536)));
        end
        drain_and_config(17'h1FFFF);
        random_site(1);
        s_axis_tvalid <= 1'b0;
        stim_done = 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 9) < 7) m_axis_tready <= 1'b1;
        else m_axis_tready <= 1'b0;
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_record(m_axis_tuser, m_axis_tdata);
    end

    initial m_axis_tready = 1'b0;

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 400000) begin
                $display("[genotype_tally_by_sex_core] ERROR");
                $finish;
            end
            if (stim_done && sb.pending.size() == 0) begin
                repeat (100) @(posedge i_clk);
                $display("covered %0d site records and %0d contig summaries",
                         sb.site_recs, sb.summaries);
                if (sb.errors == 0 && sb.pending.size() == 0)
                    $display("[genotype_tally_by_sex_core] OK");
                else
                    $display("[genotype_tally_by_sex_core] ERROR");
                $finish;
            end
        end
    end
endmodule
`default_nettype wire

[genotype_tally_by_sex_core.f]
design/gtbs_pkg.sv
design/gtbs_div.sv
design/gtbs_datapath.sv
design/gtbs_ctrl.sv
design/genotype_tally_by_sex_core.sv
tb/sv/testbench.sv
